/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the blur block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBR_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GBR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/core/gbr_pkg.sv */
`timescale 1ns / 1ps
package gbr_pkg;

    localparam int COL_W = 11;
    localparam int ROW_W = 12;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [COL_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [ROW_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [ROW_W-1:0] ROW_SAT      = 12'd4095;

    // Weights indexed [column][row].
    localparam logic [2:0] KERNEL [3][3] = '{'{3'd1, 3'd2, 3'd1},
                                             '{3'd2, 3'd4, 3'd2},
                                             '{3'd1, 3'd2, 3'd1}};
    localparam logic [12:0] ROUND_BIAS = 13'd8;
    localparam logic [12:0] CHAN_MAX   = 13'd255;

    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = 3;
    localparam int OQ_CW    = 4;

    // Red in bits 7:0, green in 15:8, blue in 23:16.
    typedef logic [23:0] pix_t;

    typedef struct packed {
        pix_t two_above;
        pix_t above;
    } lb_entry_t;

    // One channel of the window, indexed [column][row].
    typedef logic [2:0][2:0][7:0] chan_win_t;
    typedef logic [2:0][2:0]      win_mask_t;

    typedef struct packed {
        logic       frame_end;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } out_item_t;

endpackage

/* rtl/core/gbr_linebuf.sv */
`timescale 1ns / 1ps
module gbr_linebuf #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
    input  gbr_pkg::lb_entry_t            wr_data,
    output gbr_pkg::lb_entry_t            rd_data
);
    import gbr_pkg::*;

    lb_entry_t mem [MAX_WIDTH];
    lb_entry_t mem_q;
    lb_entry_t fwd_data_reg;
    logic      fwd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q <= mem[rd_addr];
        end
    end

    // A read of the entry being written in the same cycle takes the new data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : mem_q;

endmodule

/* rtl/core/gbr_lane.sv */
`timescale 1ns / 1ps
module gbr_lane (
    input  logic                aclk,
    input  logic                en,
    input  gbr_pkg::chan_win_t  win,
    input  gbr_pkg::win_mask_t  mask,
    output logic [7:0]          result
);
    import gbr_pkg::*;

    logic [12:0] sum;
    logic [12:0] rounded;
    logic [7:0]  result_reg;
    logic [7:0]  result_next;

    always_comb begin
        sum = '0;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if (mask[c][r]) begin
                    sum = sum + 13'(win[c][r]) * 13'(KERNEL[c][r]);
                end
            end
        end
        rounded = (sum + ROUND_BIAS) >> 4;
        result_next = (rounded > CHAN_MAX) ? 8'hFF : rounded[7:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

/* rtl/core/gbr_outq.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gbr_outq (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  gbr_pkg::out_item_t        push_data,
    output logic [gbr_pkg::OQ_CW-1:0] count,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [23:0]               m_tdata,   // out_red, out_green, out_blue
    output logic                      m_tlast    // frame_end
);
    import gbr_pkg::*;

    out_item_t          store_reg [OQ_DEPTH];
    logic [OQ_AW-1:0]   wr_ptr_reg;
    logic [OQ_AW-1:0]   rd_ptr_reg;
    logic [OQ_CW-1:0]   count_reg;
    logic               pop;
    out_item_t          head;

    assign pop  = m_tvalid && m_tready;
    assign head = store_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign count    = count_reg;
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {head.blue, head.green, head.red};
    assign m_tlast  = head.frame_end;

    `GBR_ASSERT_SAME(a_no_overflow, aclk, aresetn, push, (count_reg < OQ_CW'(OQ_DEPTH)) || pop)

endmodule

/* rtl/core/gaussian_blur_3x3_rgb.sv */
`timescale 1ns / 1ps
// From the item that completes it, a result passes the p1, window/p2 and lane result
// registers into the output queue; it belongs to the pixel taken image_width+1 items earlier.
// Throughput: one item per cycle, set by the line buffer doing one read and one write
// per cycle; the input stalls only while queued and in-flight items fill the 8-entry queue.
// Reset: synchronous, active low; clears counters, pipeline valid flags and queue, and sets
// the image size to 640x480; the line buffer is not cleared.
`include "assert_macros.svh"
module gaussian_blur_3x3_rgb #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // in_red, in_green, in_blue
    input  logic                              s_tuser,   // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // out_red, out_green, out_blue
    output logic                              m_tlast,   // frame_end
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gbr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [gbr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import gbr_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WCLAMP = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;

    logic [COL_W-1:0] width_reg;
    logic [ROW_W-1:0] height_reg;
    logic [COL_W-1:0] eff_w;
    logic [ROW_W-1:0] eff_h;

    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic             first_reg, first_next;

    logic             accept;
    logic             emit;
    logic             last;
    logic [COL_W:0]   in_col_inc;
    logic [COL_W:0]   out_col_inc;
    logic [ROW_W:0]   out_row_inc;
    win_mask_t        mask;

    logic             p1_valid_reg, p1_emit_reg, p1_last_reg, p1_zero_reg;
    win_mask_t        p1_mask_reg;
    pix_t             p1_pix_reg;
    logic [AW-1:0]    p1_addr_reg;
    logic             p2_valid_reg, p2_last_reg;
    win_mask_t        p2_mask_reg;
    logic             p3_valid_reg, p3_last_reg;

    lb_entry_t        lb_rd;
    lb_entry_t        lb_wr;
    logic [2:0][2:0][23:0] win_reg;
    chan_win_t        chan_win [3];
    logic [7:0]       lane_out [3];
    out_item_t        q_item;
    logic [OQ_CW-1:0] q_count;
    logic [OQ_CW-1:0] in_flight;

    // Configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[COL_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            eff_w = COL_W'(1);
        end else if (32'(width_reg) > WCLAMP) begin
            eff_w = COL_W'(WCLAMP);
        end else begin
            eff_w = width_reg;
        end
        eff_h = (height_reg == '0) ? ROW_W'(1) : height_reg;
    end

    // Input side and position counters
    assign in_flight = OQ_CW'(p1_valid_reg) + OQ_CW'(p2_valid_reg) + OQ_CW'(p3_valid_reg);
    assign s_tready  = (q_count + in_flight) < OQ_CW'(OQ_DEPTH);
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        emit = (in_row_reg > ROW_W'(1)) || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
        in_col_inc  = {1'b0, in_col_reg} + 1'b1;
        out_col_inc = {1'b0, out_col_reg} + 1'b1;
        out_row_inc = {1'b0, out_row_reg} + 1'b1;
        last = emit && (out_row_inc >= {1'b0, eff_h}) && (out_col_inc >= {1'b0, eff_w});

        mask[0] = {out_row_inc < {1'b0, eff_h}, 1'b1, out_row_reg != '0}
                  & {3{out_col_reg != '0}};
        mask[1] = {out_row_inc < {1'b0, eff_h}, 1'b1, out_row_reg != '0};
        mask[2] = {out_row_inc < {1'b0, eff_h}, 1'b1, out_row_reg != '0}
                  & {3{out_col_inc < {1'b0, eff_w}}};

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        first_next   = first_reg;
        if (accept) begin
            first_next = 1'b0;
            if (in_col_inc >= {1'b0, eff_w}) begin
                in_col_next = '0;
                if (in_row_reg != ROW_SAT) begin
                    in_row_next = in_row_reg + 1'b1;
                end
            end else begin
                in_col_next = in_col_inc[COL_W-1:0];
            end
            if (last) begin
                // The frame's last result restarts the frame for the next item.
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                first_next   = 1'b1;
            end else if (emit) begin
                if (out_col_inc >= {1'b0, eff_w}) begin
                    out_col_next = '0;
                    out_row_next = out_row_inc[ROW_W-1:0];
                end else begin
                    out_col_next = out_col_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            first_reg    <= 1'b1;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            first_reg    <= first_next;
            p1_valid_reg <= accept;
            p2_valid_reg <= p1_valid_reg && p1_emit_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_emit_reg <= emit;
            p1_last_reg <= last;
            p1_zero_reg <= first_reg;
            p1_mask_reg <= mask;
            p1_pix_reg  <= s_tuser ? '0 : s_tdata;
            p1_addr_reg <= AW'(in_col_reg);
        end
        if (p1_valid_reg) begin
            p2_last_reg <= p1_last_reg;
            p2_mask_reg <= p1_mask_reg;
        end
        if (p2_valid_reg) begin
            p3_last_reg <= p2_last_reg;
        end
    end

    // Line buffers: both rows above share one entry per column.
    assign lb_wr.two_above = lb_rd.above;
    assign lb_wr.above     = p1_pix_reg;

    gbr_linebuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (AW'(in_col_reg)),
        .wr_en   (p1_valid_reg),
        .wr_addr (p1_addr_reg),
        .wr_data (lb_wr),
        .rd_data (lb_rd)
    );

    // Window shift; the first item of a frame shifts in from a cleared window.
    always_ff @(posedge aclk) begin
        if (p1_valid_reg) begin
            win_reg[0]    <= p1_zero_reg ? '0 : win_reg[1];
            win_reg[1]    <= p1_zero_reg ? '0 : win_reg[2];
            win_reg[2][0] <= lb_rd.two_above;
            win_reg[2][1] <= lb_rd.above;
            win_reg[2][2] <= p1_pix_reg;
        end
    end

    // One lane per colour channel.
    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        always_comb begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    chan_win[ch][c][r] = win_reg[c][r][ch*8 +: 8];
                end
            end
        end

        gbr_lane u_lane (
            .aclk   (aclk),
            .en     (p2_valid_reg),
            .win    (chan_win[ch]),
            .mask   (p2_mask_reg),
            .result (lane_out[ch])
        );
    end

    assign q_item.red       = lane_out[0];
    assign q_item.green     = lane_out[1];
    assign q_item.blue      = lane_out[2];
    assign q_item.frame_end = p3_last_reg;

    gbr_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (p3_valid_reg),
        .push_data (q_item),
        .count     (q_count),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    `GBR_ASSERT_SAME(a_credit, aclk, aresetn, 1'b1, (q_count + in_flight) <= OQ_CW'(OQ_DEPTH))
    `GBR_ASSERT_NEXT(a_stage_a, aclk, aresetn, accept, p1_valid_reg)
    `GBR_ASSERT_NEXT(a_frame_restart, aclk, aresetn, accept && last, (in_col_reg == '0) && (in_row_reg == '0) && (out_col_reg == '0) && (out_row_reg == '0) && first_reg)
    `GBR_ASSERT_SAME(a_silent_item, aclk, aresetn, p1_valid_reg && !p1_emit_reg, !p1_last_reg)

endmodule
